[sv/crle_pkg.sv]
package crle_pkg;

    localparam int MAX_RECTS  = 32;
    localparam int COORD_BITS = 16;
    localparam int SIZE_W     = COORD_BITS - 1;
    localparam int CW         = COORD_BITS + 2;
    localparam int CNT_W      = $clog2(MAX_RECTS + 1);
    localparam int IDX_W      = $clog2(MAX_RECTS);
    localparam int COLOR_W    = 32;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_SUB   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_FILL  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        GM_LEFT,
        GM_TOP,
        GM_RIGHT,
        GM_BOTTOM,
        GM_OVERLAP,
        GM_CLIP
    } geom_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_SPLIT,
        ST_FILL_RD,
        ST_FILL_USE,
        ST_RESP,
        ST_OUT
    } state_t;

    // inclusive corners
    typedef struct packed {
        logic signed [CW-1:0] x0;
        logic signed [CW-1:0] y0;
        logic signed [CW-1:0] x1;
        logic signed [CW-1:0] y1;
    } rect_t;

    typedef struct packed {
        logic  hit;
        logic  piece_ok;
        rect_t piece;
        rect_t rest;
    } geom_res_t;

endpackage

[sv/crle_if.sv]
interface crle_req_if;
    logic                                     valid;
    logic                                     ready;
    logic [1:0]                               opcode;
    logic signed [crle_pkg::COORD_BITS-1:0]   rect_x;
    logic signed [crle_pkg::COORD_BITS-1:0]   rect_y;
    logic [crle_pkg::SIZE_W-1:0]              rect_width;
    logic [crle_pkg::SIZE_W-1:0]              rect_height;
    logic [crle_pkg::COLOR_W-1:0]             fill_color;

    modport source (output valid, opcode, rect_x, rect_y, rect_width, rect_height,
                    fill_color, input ready);
    modport sink (input valid, opcode, rect_x, rect_y, rect_width, rect_height,
                  fill_color, output ready);
endinterface

interface crle_rsp_if;
    logic                                     valid;
    logic                                     ready;
    logic                                     status;
    logic [crle_pkg::CNT_W-1:0]               rect_count;
    logic signed [crle_pkg::COORD_BITS-1:0]   out_x;
    logic signed [crle_pkg::COORD_BITS-1:0]   out_y;
    logic [crle_pkg::SIZE_W-1:0]              out_width;
    logic [crle_pkg::SIZE_W-1:0]              out_height;
    logic [crle_pkg::COLOR_W-1:0]             out_color;
    logic                                     out_empty;
    logic                                     last;

    modport source (output valid, status, rect_count, out_x, out_y, out_width,
                    out_height, out_color, out_empty, last, input ready);
    modport sink (input valid, status, rect_count, out_x, out_y, out_width,
                  out_height, out_color, out_empty, last, output ready);
endinterface

[sv/crle_geom.sv]
module crle_geom (
    input  crle_pkg::geom_mode_t mode,
    input  crle_pkg::rect_t      a,
    input  crle_pkg::rect_t      c,
    output crle_pkg::geom_res_t  res
);

    crle_pkg::rect_t piece;
    crle_pkg::rect_t rest;
    logic            hit;

    always_comb
    begin
        piece = a;
        rest  = a;
        hit   = 1'b0;
        case (mode)
            crle_pkg::GM_LEFT:
            begin
                hit      = (c.x0 >= a.x0) && (c.x0 <= a.x1);
                piece.x1 = c.x0 - 2'sd1;
                rest.x0  = c.x0;
            end
            crle_pkg::GM_TOP:
            begin
                hit      = (c.y0 >= a.y0) && (c.y0 <= a.y1);
                piece.y1 = c.y0 - 2'sd1;
                rest.y0  = c.y0;
            end
            crle_pkg::GM_RIGHT:
            begin
                hit      = (c.x1 >= a.x0) && (c.x1 <= a.x1);
                piece.x0 = c.x1 + 2'sd1;
                rest.x1  = c.x1;
            end
            crle_pkg::GM_BOTTOM:
            begin
                hit      = (c.y1 >= a.y0) && (c.y1 <= a.y1);
                piece.y0 = c.y1 + 2'sd1;
                rest.y1  = c.y1;
            end
            crle_pkg::GM_OVERLAP:
            begin
                hit = (c.x1 >= c.x0) && (c.y1 >= c.y0) &&
                      (a.x0 <= c.x1) && (c.x0 <= a.x1) &&
                      (a.y0 <= c.y1) && (c.y0 <= a.y1);
            end
            crle_pkg::GM_CLIP:
            begin
                piece.x0 = (c.x0 > a.x0) ? c.x0 : a.x0;
                piece.y0 = (c.y0 > a.y0) ? c.y0 : a.y0;
                piece.x1 = (c.x1 < a.x1) ? c.x1 : a.x1;
                piece.y1 = (c.y1 < a.y1) ? c.y1 : a.y1;
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

    assign res.hit      = hit;
    assign res.piece    = piece;
    assign res.rest     = rest;
    assign res.piece_ok = (piece.x1 >= piece.x0) && (piece.y1 >= piece.y0);

endmodule

[sv/crle_table.sv]
module crle_table (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [crle_pkg::IDX_W-1:0]     wr_addr,
    input  crle_pkg::rect_t                wr_data,
    input  logic                           rd_en,
    input  logic [crle_pkg::IDX_W-1:0]     rd_addr,
    output crle_pkg::rect_t                rd_data
);

    crle_pkg::rect_t mem [crle_pkg::MAX_RECTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/clip_rect_list_engine.sv]
// channel | dir | word
// req     | in  | opcode, rect_x, rect_y, rect_width, rect_height, fill_color
// rsp     | out | status, rect_count, out_x/y, out_width/height, out_color,
//         |     | out_empty, last
// One item at a time; req.ready is low from accept until the last rsp word is taken.
// Fill: each table entry is read, clipped and sent, waiting on rsp. Add/subtract:
// each entry is read and checked for overlap, then result load and output follow;
// each hit moves the later entries down one place and runs four split steps.
// The shared geometry unit and the single table read port set this order of steps.
// rst_n clears the entry count; table contents are never cleared.
module clip_rect_list_engine (
    input  logic clk,
    input  logic rst_n,
    crle_req_if.sink   req,
    crle_rsp_if.source rsp
);

    localparam int CB = crle_pkg::COORD_BITS;
    localparam int CW = crle_pkg::CW;
    localparam int SW = crle_pkg::SIZE_W;
    localparam int NW = crle_pkg::CNT_W;
    localparam int IW = crle_pkg::IDX_W;

    crle_pkg::state_t state_reg, state_next;
    crle_pkg::op_t    op_reg, op_next;
    crle_pkg::rect_t  c_reg, c_next;
    crle_pkg::rect_t  t_reg, t_next;
    logic [crle_pkg::COLOR_W-1:0] color_reg, color_next;
    logic [NW-1:0]    cnt_reg, cnt_next;
    logic [NW-1:0]    idx_reg, idx_next;
    logic [NW-1:0]    k_reg, k_next;
    logic [1:0]       step_reg, step_next;
    logic             drop_reg, drop_next;

    logic             o_status_reg, o_status_next;
    logic signed [CB-1:0] o_x_reg, o_x_next, o_y_reg, o_y_next;
    logic [SW-1:0]    o_w_reg, o_w_next, o_h_reg, o_h_next;
    logic [crle_pkg::COLOR_W-1:0] o_color_reg, o_color_next;
    logic             o_empty_reg, o_empty_next;
    logic             o_last_reg, o_last_next;

    crle_pkg::geom_mode_t gmode;
    crle_pkg::rect_t      ga;
    crle_pkg::geom_res_t  gres;

    logic             wr_en, rd_en;
    logic [IW-1:0]    wr_addr, rd_addr;
    crle_pkg::rect_t  wr_data, rd_data;

    crle_pkg::rect_t  in_rect;
    logic [NW-1:0]    k_inc;
    logic [CW-1:0]    pw, ph;
    logic             room;

    assign k_inc = k_reg + 1'b1;
    assign room  = cnt_reg < NW'(crle_pkg::MAX_RECTS);

    always_comb
    begin
        in_rect.x0 = {{(CW-CB){req.rect_x[CB-1]}}, req.rect_x};
        in_rect.y0 = {{(CW-CB){req.rect_y[CB-1]}}, req.rect_y};
        in_rect.x1 = in_rect.x0 + $signed({{(CW-SW){1'b0}}, req.rect_width}) - 2'sd1;
        in_rect.y1 = in_rect.y0 + $signed({{(CW-SW){1'b0}}, req.rect_height}) - 2'sd1;
    end

    crle_geom u_geom (
        .mode (gmode),
        .a    (ga),
        .c    (c_reg),
        .res  (gres)
    );

    crle_table u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            crle_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    case (crle_pkg::op_t'(req.opcode))
                        crle_pkg::OP_CLEAR: state_next = crle_pkg::ST_RESP;
                        crle_pkg::OP_FILL:  state_next = (cnt_reg == '0) ?
                                                crle_pkg::ST_RESP : crle_pkg::ST_FILL_RD;
                        default:            state_next = crle_pkg::ST_SCAN;
                    endcase
                end
            end
            crle_pkg::ST_SCAN:
                state_next = (idx_reg < cnt_reg) ? crle_pkg::ST_CHECK : crle_pkg::ST_RESP;
            crle_pkg::ST_CHECK:
                state_next = gres.hit ? crle_pkg::ST_SHIFT_RD : crle_pkg::ST_SCAN;
            crle_pkg::ST_SHIFT_RD:
                state_next = (k_inc < cnt_reg) ? crle_pkg::ST_SHIFT_WR : crle_pkg::ST_SPLIT;
            crle_pkg::ST_SHIFT_WR:
                state_next = crle_pkg::ST_SHIFT_RD;
            crle_pkg::ST_SPLIT:
                state_next = (step_reg == 2'd3) ? crle_pkg::ST_SCAN : crle_pkg::ST_SPLIT;
            crle_pkg::ST_FILL_RD:
                state_next = crle_pkg::ST_FILL_USE;
            crle_pkg::ST_FILL_USE:
                state_next = crle_pkg::ST_OUT;
            crle_pkg::ST_RESP:
                state_next = crle_pkg::ST_OUT;
            crle_pkg::ST_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = o_last_reg ? crle_pkg::ST_IDLE : crle_pkg::ST_FILL_RD;
                end
            end
            default:
                state_next = crle_pkg::ST_IDLE;
        endcase
    end

    // datapath and table control
    always_comb
    begin
        op_next       = op_reg;
        c_next        = c_reg;
        t_next        = t_reg;
        color_next    = color_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        k_next        = k_reg;
        step_next     = step_reg;
        drop_next     = drop_reg;
        o_status_next = o_status_reg;
        o_x_next      = o_x_reg;
        o_y_next      = o_y_reg;
        o_w_next      = o_w_reg;
        o_h_next      = o_h_reg;
        o_color_next  = o_color_reg;
        o_empty_next  = o_empty_reg;
        o_last_next   = o_last_reg;
        gmode         = crle_pkg::GM_CLIP;
        ga            = rd_data;
        wr_en         = 1'b0;
        wr_addr       = cnt_reg[IW-1:0];
        wr_data       = c_reg;
        rd_en         = 1'b0;
        rd_addr       = idx_reg[IW-1:0];
        pw            = '0;
        ph            = '0;
        case (state_reg)
            crle_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = crle_pkg::op_t'(req.opcode);
                    c_next     = in_rect;
                    color_next = req.fill_color;
                    idx_next   = '0;
                    drop_next  = 1'b0;
                    if (crle_pkg::op_t'(req.opcode) == crle_pkg::OP_CLEAR)
                    begin
                        cnt_next = '0;
                    end
                end
            end
            crle_pkg::ST_SCAN:
            begin
                if (idx_reg < cnt_reg)
                begin
                    rd_en = 1'b1;
                end
                else if (op_reg == crle_pkg::OP_ADD &&
                         c_reg.x1 >= c_reg.x0 && c_reg.y1 >= c_reg.y0)
                begin
                    if (room)
                    begin
                        wr_en    = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                end
            end
            crle_pkg::ST_CHECK:
            begin
                gmode = crle_pkg::GM_OVERLAP;
                if (gres.hit)
                begin
                    t_next = rd_data;
                    k_next = idx_reg;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            crle_pkg::ST_SHIFT_RD:
            begin
                rd_addr = k_inc[IW-1:0];
                if (k_inc < cnt_reg)
                begin
                    rd_en = 1'b1;
                end
                else
                begin
                    cnt_next  = cnt_reg - 1'b1;
                    step_next = 2'd0;
                end
            end
            crle_pkg::ST_SHIFT_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = k_reg[IW-1:0];
                wr_data = rd_data;
                k_next  = k_inc;
            end
            crle_pkg::ST_SPLIT:
            begin
                ga      = t_reg;
                wr_data = gres.piece;
                case (step_reg)
                    2'd0:    gmode = crle_pkg::GM_LEFT;
                    2'd1:    gmode = crle_pkg::GM_TOP;
                    2'd2:    gmode = crle_pkg::GM_RIGHT;
                    default: gmode = crle_pkg::GM_BOTTOM;
                endcase
                if (gres.hit)
                begin
                    t_next = gres.rest;
                    if (gres.piece_ok)
                    begin
                        if (room)
                        begin
                            wr_en    = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                        end
                        else
                        begin
                            drop_next = 1'b1;
                        end
                    end
                end
                step_next = step_reg + 2'd1;
            end
            crle_pkg::ST_FILL_RD:
            begin
                rd_en = 1'b1;
            end
            crle_pkg::ST_FILL_USE:
            begin
                gmode         = crle_pkg::GM_CLIP;
                pw            = gres.piece.x1 - gres.piece.x0 + 2'sd1;
                ph            = gres.piece.y1 - gres.piece.y0 + 2'sd1;
                o_status_next = 1'b0;
                o_color_next  = color_reg;
                o_empty_next  = !gres.piece_ok;
                o_last_next   = (NW'(idx_reg + 1'b1) == cnt_reg);
                o_x_next      = gres.piece_ok ? gres.piece.x0[CB-1:0] : '0;
                o_y_next      = gres.piece_ok ? gres.piece.y0[CB-1:0] : '0;
                o_w_next      = gres.piece_ok ? pw[SW-1:0] : '0;
                o_h_next      = gres.piece_ok ? ph[SW-1:0] : '0;
            end
            crle_pkg::ST_RESP:
            begin
                pw            = c_reg.x1 - c_reg.x0 + 2'sd1;
                ph            = c_reg.y1 - c_reg.y0 + 2'sd1;
                o_status_next = drop_reg;
                o_last_next   = 1'b1;
                if (op_reg == crle_pkg::OP_FILL)
                begin
                    o_x_next     = c_reg.x0[CB-1:0];
                    o_y_next     = c_reg.y0[CB-1:0];
                    o_w_next     = pw[SW-1:0];
                    o_h_next     = ph[SW-1:0];
                    o_color_next = color_reg;
                    o_empty_next = !(c_reg.x1 >= c_reg.x0 && c_reg.y1 >= c_reg.y0);
                end
                else
                begin
                    o_x_next     = '0;
                    o_y_next     = '0;
                    o_w_next     = '0;
                    o_h_next     = '0;
                    o_color_next = '0;
                    o_empty_next = 1'b0;
                end
            end
            crle_pkg::ST_OUT:
            begin
                if (rsp.ready && !o_last_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crle_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        c_reg        <= c_next;
        t_reg        <= t_next;
        color_reg    <= color_next;
        idx_reg      <= idx_next;
        k_reg        <= k_next;
        step_reg     <= step_next;
        drop_reg     <= drop_next;
        o_status_reg <= o_status_next;
        o_x_reg      <= o_x_next;
        o_y_reg      <= o_y_next;
        o_w_reg      <= o_w_next;
        o_h_reg      <= o_h_next;
        o_color_reg  <= o_color_next;
        o_empty_reg  <= o_empty_next;
        o_last_reg   <= o_last_next;
    end

    assign req.ready      = (state_reg == crle_pkg::ST_IDLE);
    assign rsp.valid      = (state_reg == crle_pkg::ST_OUT);
    assign rsp.status     = o_status_reg;
    assign rsp.rect_count = cnt_reg;
    assign rsp.out_x      = o_x_reg;
    assign rsp.out_y      = o_y_reg;
    assign rsp.out_width  = o_w_reg;
    assign rsp.out_height = o_h_reg;
    assign rsp.out_color  = o_color_reg;
    assign rsp.out_empty  = o_empty_reg;
    assign rsp.last       = o_last_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= NW'(crle_pkg::MAX_RECTS))
        else $error("entry count above table size");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && state_reg != crle_pkg::ST_SHIFT_WR) |-> room)
        else $error("append into full table");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("ready high right after accept");

    a_shift_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == crle_pkg::ST_SHIFT_WR) |-> (k_inc < cnt_reg))
        else $error("shift beyond table fill");

endmodule
